// ----- rtl/omv_pkg.sv -----
package omv_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned AS_W     = 32;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned VERD_W   = 3;
    localparam int unsigned OUT_W    = 56;

    localparam logic [15:0] AS_STANDIN       = 16'd23456;
    localparam logic [7:0]  CAP_MULTIPROTO   = 8'd1;
    localparam logic [7:0]  CAP_REFRESH      = 8'd2;
    localparam logic [7:0]  CAP_AS4          = 8'd65;
    localparam logic [7:0]  CAP_PRIVATE      = 8'd128;
    localparam logic [7:0]  SAFI_LABELED     = 8'd4;
    localparam logic [7:0]  OPT_AUTH         = 8'd1;
    localparam logic [7:0]  OPT_CAPS         = 8'd2;
    localparam logic [7:0]  BGP_VERSION      = 8'd4;

    // header byte positions (index of the byte just taken)
    localparam logic [7:0]  HDR_AS_LAST      = 8'd2;
    localparam logic [7:0]  HDR_HOLD_LAST    = 8'd4;
    localparam logic [7:0]  HDR_OPTLEN       = 8'd9;

    // capability value byte positions
    localparam logic [7:0]  CV_AFI_LAST      = 8'd2;
    localparam logic [7:0]  CV_WORD_LAST     = 8'd4;
    localparam logic [7:0]  CAP_MIN_LEN      = 8'd4;

    localparam logic        CFG_PEER_AS      = 1'b0;
    localparam logic        CFG_AS4_EN       = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HEADER,
        PH_PCODE,
        PH_PLEN,
        PH_CCODE,
        PH_CLEN,
        PH_CVAL
    } t_phase;

    typedef enum logic [VERD_W-1:0] {
        V_OK        = 3'd0,
        V_VERSION   = 3'd1,
        V_BAD_AS    = 3'd2,
        V_HOLD_TIME = 3'd3,
        V_AUTH      = 3'd4,
        V_BAD_PARAM = 3'd5,
        V_BAD_CAP   = 3'd6
    } t_verdict;

endpackage

// ----- rtl/open_message_validator.sv -----
// open message validator
// input stream: one word per byte of an open message body, starting at the
// version byte, which is marked by tuser. a marked byte restarts the parse.
// output stream: one word per message, the verdict, given at the first error
// or at the end of the optional parameters; bytes after a verdict are
// dropped until the next marked byte.
// the verdict word goes to the output register, or to the skid register
// when the output word is not yet taken. throughput: one byte per cycle
// while the skid register is empty, set by the single parse step between
// the input handshake and the result register. when the receiver stalls,
// a second result waits in the skid register and the input side keeps
// taking bytes; input ready drops only while the skid register is full.
// reset clears the parse state, the held fields, the valid flags of both
// output registers and the configuration registers (peer as 0, 4-octet as
// check off). configuration is written through i_cfg_we, i_cfg_addr and
// i_cfg_wdata (index 0 expected peer as, index 1 4-octet as check enable);
// the user must write it only while the block is idle, which is not enforced.
module open_message_validator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,   // msg_byte
    input  logic                         i_s_tuser,   // start_of_message
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // verdict[2:0], hold_time[18:3], peer_as4[50:19], as4_negotiated[51], zero fill
    output logic [omv_pkg::OUT_W-1:0]    o_m_tdata,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [omv_pkg::AS_W-1:0]     i_cfg_wdata
);

    logic [omv_pkg::AS_W-1:0]   r_exp_as;
    logic                       r_as4_en;

    omv_pkg::t_phase            r_phase, n_phase;
    logic [7:0]                 r_byte_idx, n_byte_idx;
    logic [7:0]                 r_opt_len, n_opt_len;
    logic [8:0]                 r_opt_used, n_opt_used;
    logic [7:0]                 r_par_rem, n_par_rem;
    logic [7:0]                 r_cap_code, n_cap_code;
    logic [7:0]                 r_cap_rem, n_cap_rem;
    logic [31:0]                r_acc, n_acc;
    logic [15:0]                r_hold, n_hold;
    logic [31:0]                r_as4, n_as4;
    logic                       r_as4_ok, n_as4_ok;

    logic                       r_out_valid;
    logic [omv_pkg::OUT_W-1:0]  r_out_data;
    logic                       r_skd_valid;
    logic [omv_pkg::OUT_W-1:0]  r_skd_data;

    logic                       in_fire;
    logic                       emit;
    omv_pkg::t_verdict          verdict;
    logic [7:0]                 b;
    logic [15:0]                as2;
    logic [omv_pkg::OUT_W-1:0]  res_word;

    assign o_s_tready = !r_skd_valid;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign b          = i_s_tdata;
    assign as2        = (r_exp_as[31:16] != 16'd0) ? omv_pkg::AS_STANDIN : r_exp_as[15:0];

    always_comb begin
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_opt_len  = r_opt_len;
        n_opt_used = r_opt_used;
        n_par_rem  = r_par_rem;
        n_cap_code = r_cap_code;
        n_cap_rem  = r_cap_rem;
        n_acc      = r_acc;
        n_hold     = r_hold;
        n_as4      = r_as4;
        n_as4_ok   = r_as4_ok;
        emit       = 1'b0;
        verdict    = omv_pkg::V_OK;

        if (i_s_tuser) begin
            n_hold     = '0;
            n_as4      = '0;
            n_as4_ok   = 1'b0;
            n_byte_idx = '0;
            n_acc      = '0;
            n_opt_len  = '0;
            n_opt_used = '0;
            if (b != omv_pkg::BGP_VERSION) begin
                emit    = 1'b1;
                verdict = omv_pkg::V_VERSION;
            end else begin
                n_phase = omv_pkg::PH_HEADER;
            end
        end else begin
            case (r_phase)
                omv_pkg::PH_HEADER: begin
                    n_byte_idx = r_byte_idx + 8'd1;
                    n_acc      = {r_acc[23:0], b};
                    case (n_byte_idx)
                        omv_pkg::HDR_AS_LAST: begin
                            if (n_acc[15:0] != as2) begin
                                emit    = 1'b1;
                                verdict = omv_pkg::V_BAD_AS;
                            end
                        end
                        omv_pkg::HDR_HOLD_LAST: begin
                            n_hold = n_acc[15:0];
                            if (n_hold == 16'd1 || n_hold == 16'd2) begin
                                emit    = 1'b1;
                                verdict = omv_pkg::V_HOLD_TIME;
                            end
                        end
                        omv_pkg::HDR_OPTLEN: begin
                            n_opt_len  = b;
                            n_opt_used = '0;
                            if (b == 8'd0) begin
                                emit    = 1'b1;
                                verdict = omv_pkg::V_OK;
                            end else begin
                                n_phase = omv_pkg::PH_PCODE;
                            end
                        end
                        default: ;
                    endcase
                end
                omv_pkg::PH_PCODE: begin
                    n_opt_used = r_opt_used + 9'd1;
                    if (b == omv_pkg::OPT_AUTH) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_AUTH;
                    end else if (b != omv_pkg::OPT_CAPS ||
                                 n_opt_used >= {1'b0, r_opt_len}) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_PARAM;
                    end else begin
                        n_phase = omv_pkg::PH_PLEN;
                    end
                end
                omv_pkg::PH_PLEN: begin
                    n_opt_used = r_opt_used + 9'd1;
                    if (n_opt_used > {1'b0, r_opt_len} ||
                        {1'b0, b} > ({1'b0, r_opt_len} - n_opt_used)) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_PARAM;
                    end else begin
                        n_par_rem = b;
                        if (b != 8'd0) begin
                            n_phase = omv_pkg::PH_CCODE;
                        end else if (n_opt_used >= {1'b0, r_opt_len}) begin
                            emit    = 1'b1;
                            verdict = omv_pkg::V_OK;
                        end else begin
                            n_phase = omv_pkg::PH_PCODE;
                        end
                    end
                end
                omv_pkg::PH_CCODE: begin
                    n_opt_used = r_opt_used + 9'd1;
                    if (r_par_rem != 8'd0) begin
                        n_par_rem = r_par_rem - 8'd1;
                    end
                    n_cap_code = b;
                    if (!(b inside {omv_pkg::CAP_MULTIPROTO, omv_pkg::CAP_REFRESH,
                                    omv_pkg::CAP_AS4, omv_pkg::CAP_PRIVATE})) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_CAP;
                    end else if (n_par_rem == 8'd0) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_PARAM;
                    end else begin
                        n_phase = omv_pkg::PH_CLEN;
                    end
                end
                omv_pkg::PH_CLEN: begin
                    n_opt_used = r_opt_used + 9'd1;
                    if (r_par_rem != 8'd0) begin
                        n_par_rem = r_par_rem - 8'd1;
                    end
                    if (b > n_par_rem) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_PARAM;
                    end else if ((r_cap_code == omv_pkg::CAP_MULTIPROTO ||
                                  r_cap_code == omv_pkg::CAP_AS4) &&
                                 b < omv_pkg::CAP_MIN_LEN) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_CAP;
                    end else begin
                        n_cap_rem  = b;
                        n_byte_idx = '0;
                        n_acc      = '0;
                        if (b != 8'd0) begin
                            n_phase = omv_pkg::PH_CVAL;
                        end else if (n_par_rem != 8'd0) begin
                            n_phase = omv_pkg::PH_CCODE;
                        end else if (n_opt_used >= {1'b0, r_opt_len}) begin
                            emit    = 1'b1;
                            verdict = omv_pkg::V_OK;
                        end else begin
                            n_phase = omv_pkg::PH_PCODE;
                        end
                    end
                end
                omv_pkg::PH_CVAL: begin
                    n_opt_used = r_opt_used + 9'd1;
                    if (r_par_rem != 8'd0) begin
                        n_par_rem = r_par_rem - 8'd1;
                    end
                    if (r_cap_rem != 8'd0) begin
                        n_cap_rem = r_cap_rem - 8'd1;
                    end
                    n_acc = {r_acc[23:0], b};
                    if (r_byte_idx != 8'hFF) begin
                        n_byte_idx = r_byte_idx + 8'd1;
                    end
                    if (r_cap_code == omv_pkg::CAP_MULTIPROTO &&
                        n_byte_idx == omv_pkg::CV_AFI_LAST &&
                        n_acc[15:0] != 16'd1 && n_acc[15:0] != 16'd2) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_CAP;
                    end else if (r_cap_code == omv_pkg::CAP_MULTIPROTO &&
                                 n_byte_idx == omv_pkg::CV_WORD_LAST &&
                                 (b == omv_pkg::SAFI_LABELED ||
                                  !(b inside {[8'd1:8'd3]}))) begin
                        emit    = 1'b1;
                        verdict = omv_pkg::V_BAD_CAP;
                    end else begin
                        if (r_cap_code == omv_pkg::CAP_AS4 &&
                            n_byte_idx == omv_pkg::CV_WORD_LAST) begin
                            n_as4 = n_acc;
                            if (r_as4_en) begin
                                if (n_acc != r_exp_as) begin
                                    emit    = 1'b1;
                                    verdict = omv_pkg::V_BAD_AS;
                                end else begin
                                    n_as4_ok = 1'b1;
                                end
                            end
                        end
                        if (!emit && n_cap_rem == 8'd0) begin
                            if (n_par_rem != 8'd0) begin
                                n_phase = omv_pkg::PH_CCODE;
                            end else if (n_opt_used >= {1'b0, r_opt_len}) begin
                                emit    = 1'b1;
                                verdict = omv_pkg::V_OK;
                            end else begin
                                n_phase = omv_pkg::PH_PCODE;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (emit) begin
            n_phase = omv_pkg::PH_WAIT;
        end
    end

    assign res_word = {4'd0, n_as4_ok, n_as4, n_hold, verdict};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_as <= '0;
            r_as4_en <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == omv_pkg::CFG_PEER_AS) begin
                r_exp_as <= i_cfg_wdata;
            end else begin
                r_as4_en <= i_cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= omv_pkg::PH_WAIT;
            r_byte_idx <= '0;
            r_opt_len  <= '0;
            r_opt_used <= '0;
            r_par_rem  <= '0;
            r_cap_code <= '0;
            r_cap_rem  <= '0;
            r_acc      <= '0;
            r_hold     <= '0;
            r_as4      <= '0;
            r_as4_ok   <= 1'b0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_byte_idx <= n_byte_idx;
            r_opt_len  <= n_opt_len;
            r_opt_used <= n_opt_used;
            r_par_rem  <= n_par_rem;
            r_cap_code <= n_cap_code;
            r_cap_rem  <= n_cap_rem;
            r_acc      <= n_acc;
            r_hold     <= n_hold;
            r_as4      <= n_as4;
            r_as4_ok   <= n_as4_ok;
        end
    end

    // output register with a skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (in_fire && emit) begin
            if (!r_out_valid || i_m_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (r_out_valid && i_m_tready) begin
            r_out_valid <= r_skd_valid;
            r_skd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            if (!r_out_valid || i_m_tready) begin
                r_out_data <= res_word;
            end else begin
                r_skd_data <= res_word;
            end
        end else if (r_out_valid && i_m_tready && r_skd_valid) begin
            r_out_data <= r_skd_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_bad_version_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_tuser && i_s_tdata != omv_pkg::BGP_VERSION)
        |=> (r_phase == omv_pkg::PH_WAIT && r_out_valid))
        else $error("bad version did not end the parse with a word");

    a_good_version_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_tuser && i_s_tdata == omv_pkg::BGP_VERSION)
        |=> (r_phase == omv_pkg::PH_HEADER && r_byte_idx == 8'd0))
        else $error("version byte did not start the header");

    a_wait_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_s_tuser && r_phase == omv_pkg::PH_WAIT)
        |=> $stable(r_phase))
        else $error("byte outside a message changed the parse");

endmodule

// ----- test/open_message_validator_test.sv -----
module open_message_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_OFF_LEN = 300;
    localparam logic [15:0] PEER16 = 16'd65000;

    typedef struct packed {
        logic       sof;
        logic [7:0] b;
    } t_msg_word;

    typedef struct packed {
        logic              as4_neg;
        logic [31:0]       peer_as4;
        logic [15:0]       hold;
        omv_pkg::t_verdict verdict;
    } t_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [7:0]                   i_s_tdata = '0;
    logic                         i_s_tuser = 1'b0;
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [omv_pkg::OUT_W-1:0]    o_m_tdata;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_addr = 1'b0;
    logic [omv_pkg::AS_W-1:0]     i_cfg_wdata = '0;

    open_message_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // msg_byte
        .i_s_tuser   (i_s_tuser),    // start_of_message
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // verdict, hold_time, peer_as4, as4_negotiated
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    t_msg_word pending_words[$];
    t_result   verdicts_due[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_off_req = 0;
    int errors = 0;
    int words_sent = 0;
    int verdicts_seen = 0;
    int verdict_tally[7];

    // parser shadow state
    logic [31:0]     want_peer_as = '0;
    logic            want_as4_en = 1'b0;
    omv_pkg::t_phase walk_phase = omv_pkg::PH_WAIT;
    logic [7:0]      field_pos = '0;
    logic [7:0]      opt_len = '0;
    logic [8:0]      opt_used = '0;
    logic [7:0]      par_left = '0;
    logic [7:0]      cap_code = '0;
    logic [7:0]      cap_left = '0;
    logic [31:0]     acc = '0;
    logic [15:0]     got_hold = '0;
    logic [31:0]     got_as4 = '0;
    logic            as4_ok = 1'b0;

    function automatic bit close_param();
        if (opt_used >= {1'b0, opt_len}) return 1'b1;
        walk_phase = omv_pkg::PH_PCODE;
        return 1'b0;
    endfunction

    function automatic bit close_cap();
        if (par_left == 8'd0) return close_param();
        walk_phase = omv_pkg::PH_CCODE;
        return 1'b0;
    endfunction

    // advance the open parser by one byte, returns 1 when a verdict is due
    function automatic bit open_step(input logic [7:0] b, input logic sof,
                                     output t_result res);
        logic [15:0]       as2;
        bit                done;
        omv_pkg::t_verdict v;
        done = 1'b0;
        v = omv_pkg::V_OK;
        res = '0;
        if (sof) begin
            got_hold = '0;
            got_as4 = '0;
            as4_ok = 1'b0;
            field_pos = '0;
            acc = '0;
            opt_len = '0;
            opt_used = '0;
            if (b != omv_pkg::BGP_VERSION) begin
                v = omv_pkg::V_VERSION;
                done = 1'b1;
            end else begin
                walk_phase = omv_pkg::PH_HEADER;
            end
        end else begin
            case (walk_phase)
                omv_pkg::PH_HEADER: begin
                    field_pos = field_pos + 8'd1;
                    acc = {acc[23:0], b};
                    as2 = (want_peer_as > 32'd65535) ? omv_pkg::AS_STANDIN
                                                     : want_peer_as[15:0];
                    if (field_pos == omv_pkg::HDR_AS_LAST && acc[15:0] != as2) begin
                        v = omv_pkg::V_BAD_AS;
                        done = 1'b1;
                    end else if (field_pos == omv_pkg::HDR_HOLD_LAST) begin
                        got_hold = acc[15:0];
                        if (got_hold == 16'd1 || got_hold == 16'd2) begin
                            v = omv_pkg::V_HOLD_TIME;
                            done = 1'b1;
                        end
                    end else if (field_pos == omv_pkg::HDR_OPTLEN) begin
                        opt_len = b;
                        opt_used = '0;
                        if (b == 8'd0) done = 1'b1;
                        else walk_phase = omv_pkg::PH_PCODE;
                    end
                end
                omv_pkg::PH_PCODE: begin
                    opt_used = opt_used + 9'd1;
                    if (b == omv_pkg::OPT_AUTH) begin
                        v = omv_pkg::V_AUTH;
                        done = 1'b1;
                    end else if (b != omv_pkg::OPT_CAPS || opt_used >= {1'b0, opt_len}) begin
                        v = omv_pkg::V_BAD_PARAM;
                        done = 1'b1;
                    end else begin
                        walk_phase = omv_pkg::PH_PLEN;
                    end
                end
                omv_pkg::PH_PLEN: begin
                    opt_used = opt_used + 9'd1;
                    if (opt_used > {1'b0, opt_len} ||
                        {1'b0, b} > ({1'b0, opt_len} - opt_used)) begin
                        v = omv_pkg::V_BAD_PARAM;
                        done = 1'b1;
                    end else begin
                        par_left = b;
                        if (b == 8'd0) done = close_param();
                        else walk_phase = omv_pkg::PH_CCODE;
                    end
                end
                omv_pkg::PH_CCODE: begin
                    opt_used = opt_used + 9'd1;
                    if (par_left != 8'd0) par_left = par_left - 8'd1;
                    cap_code = b;
                    if (b != omv_pkg::CAP_MULTIPROTO && b != omv_pkg::CAP_REFRESH &&
                        b != omv_pkg::CAP_AS4 && b != omv_pkg::CAP_PRIVATE) begin
                        v = omv_pkg::V_BAD_CAP;
                        done = 1'b1;
                    end else if (par_left == 8'd0) begin
                        v = omv_pkg::V_BAD_PARAM;
                        done = 1'b1;
                    end else begin
                        walk_phase = omv_pkg::PH_CLEN;
                    end
                end
                omv_pkg::PH_CLEN: begin
                    opt_used = opt_used + 9'd1;
                    if (par_left != 8'd0) par_left = par_left - 8'd1;
                    if (b > par_left) begin
                        v = omv_pkg::V_BAD_PARAM;
                        done = 1'b1;
                    end else if ((cap_code == omv_pkg::CAP_MULTIPROTO ||
                                  cap_code == omv_pkg::CAP_AS4) &&
                                 b < omv_pkg::CAP_MIN_LEN) begin
                        v = omv_pkg::V_BAD_CAP;
                        done = 1'b1;
                    end else begin
                        cap_left = b;
                        field_pos = '0;
                        acc = '0;
                        if (b == 8'd0) done = close_cap();
                        else walk_phase = omv_pkg::PH_CVAL;
                    end
                end
                omv_pkg::PH_CVAL: begin
                    opt_used = opt_used + 9'd1;
                    if (par_left != 8'd0) par_left = par_left - 8'd1;
                    if (cap_left != 8'd0) cap_left = cap_left - 8'd1;
                    acc = {acc[23:0], b};
                    if (field_pos < 8'd255) field_pos = field_pos + 8'd1;
                    if (cap_code == omv_pkg::CAP_MULTIPROTO) begin
                        if (field_pos == omv_pkg::CV_AFI_LAST) begin
                            if (acc[15:0] != 16'd1 && acc[15:0] != 16'd2) begin
                                v = omv_pkg::V_BAD_CAP;
                                done = 1'b1;
                            end
                        end else if (field_pos == omv_pkg::CV_WORD_LAST) begin
                            if (b == omv_pkg::SAFI_LABELED || b < 8'd1 || b > 8'd3) begin
                                v = omv_pkg::V_BAD_CAP;
                                done = 1'b1;
                            end
                        end
                    end else if (cap_code == omv_pkg::CAP_AS4 &&
                                 field_pos == omv_pkg::CV_WORD_LAST) begin
                        got_as4 = acc;
                        if (want_as4_en) begin
                            if (got_as4 != want_peer_as) begin
                                v = omv_pkg::V_BAD_AS;
                                done = 1'b1;
                            end else begin
                                as4_ok = 1'b1;
                            end
                        end
                    end
                    if (!done && cap_left == 8'd0) done = close_cap();
                end
                default: ;
            endcase
        end
        if (done) begin
            res.verdict = v;
            res.hold = got_hold;
            res.peer_as4 = got_as4;
            res.as4_neg = as4_ok;
            walk_phase = omv_pkg::PH_WAIT;
        end
        return done;
    endfunction

    task automatic report_miss(input string s);
        errors++;
        if (errors <= 10) $display("mismatch: %s", s);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_words
        t_msg_word nxt;
        t_result   res;
        logic      busy;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            busy = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                words_sent++;
                if (open_step(i_s_tdata, i_s_tuser, res)) verdicts_due.push_back(res);
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pending_words.pop_front();
                    i_s_tdata <= nxt.b;
                    i_s_tuser <= nxt.sof;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_verdicts
        t_result want;
        logic    rdy;
        int      hold_seen;
        int      hold_left;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                verdicts_seen++;
                if (verdicts_due.size() == 0) begin
                    report_miss($sformatf("verdict word %0h with none pending", o_m_tdata));
                end else begin
                    want = verdicts_due.pop_front();
                    verdict_tally[want.verdict]++;
                    if (o_m_tdata[2:0] !== want.verdict || o_m_tdata[18:3] !== want.hold ||
                        o_m_tdata[50:19] !== want.peer_as4 || o_m_tdata[51] !== want.as4_neg)
                        report_miss($sformatf(
                            "exp v=%0d hold=%0d as4=%0h neg=%0d got v=%0d hold=%0d as4=%0h neg=%0d",
                            want.verdict, want.hold, want.peer_as4, want.as4_neg,
                            o_m_tdata[2:0], o_m_tdata[18:3], o_m_tdata[50:19], o_m_tdata[51]));
                end
            end
            if (hold_off_req != hold_seen) begin
                hold_seen = hold_off_req;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                rdy = ($urandom_range(99) >= rx_stall_pct);
            end
            i_m_tready <= rdy;
        end
    end

    // watchdog
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic addr, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        if (addr == omv_pkg::CFG_PEER_AS) want_peer_as = val;
        else want_as4_en = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_s_tvalid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [79:0] hdr(input logic [15:0] as2, input logic [15:0] hold,
                                        input logic [7:0] olen);
        return {omv_pkg::BGP_VERSION, as2, hold, 32'hC0A8_0001, olen};
    endfunction

    // queue n bytes, most significant first, the first one marked as start
    task automatic send(input logic [255:0] v, input int n);
        t_msg_word w;
        for (int i = n - 1; i >= 0; i--) begin
            w.b = v[8*i +: 8];
            w.sof = (i == n - 1);
            pending_words.push_back(w);
        end
    endtask

    task automatic loose(input logic [7:0] b);
        t_msg_word w;
        w.b = b;
        w.sof = 1'b0;
        pending_words.push_back(w);
    endtask

    task automatic add_random_msg(output int nbytes);
        logic [7:0]  m[$];
        logic [7:0]  opts[$];
        logic [7:0]  par[$];
        logic [7:0]  val[$];
        logic [15:0] as2;
        logic [15:0] hold;
        logic [15:0] afi;
        logic [31:0] w;
        logic [7:0]  code;
        logic [7:0]  safi;
        int          idx;
        t_msg_word   x;
        as2 = (want_peer_as > 32'd65535) ? omv_pkg::AS_STANDIN : want_peer_as[15:0];
        if ($urandom_range(19) == 0) as2 = 16'($urandom);
        case ($urandom_range(7))
            0: hold = 16'd0;
            1: hold = 16'($urandom_range(1, 2));
            2: hold = 16'hFFFF;
            3: hold = 16'd3;
            default: hold = 16'($urandom);
        endcase
        w = $urandom;
        m.push_back(omv_pkg::BGP_VERSION);
        m.push_back(as2[15:8]);
        m.push_back(as2[7:0]);
        m.push_back(hold[15:8]);
        m.push_back(hold[7:0]);
        for (int i = 3; i >= 0; i--) m.push_back(w[8*i +: 8]);
        repeat ($urandom_range(0, 3)) begin
            par.delete();
            repeat ($urandom_range(0, 3)) begin
                val.delete();
                case ($urandom_range(9))
                    0, 1, 2: begin
                        code = omv_pkg::CAP_MULTIPROTO;
                        afi = ($urandom_range(7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(1, 2));
                        safi = ($urandom_range(7) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(1, 3));
                        val.push_back(afi[15:8]);
                        val.push_back(afi[7:0]);
                        val.push_back(8'($urandom));
                        val.push_back(safi);
                    end
                    3, 4: begin
                        code = omv_pkg::CAP_AS4;
                        w = ($urandom_range(3) == 0) ? $urandom : want_peer_as;
                        for (int i = 3; i >= 0; i--) val.push_back(w[8*i +: 8]);
                    end
                    5: code = omv_pkg::CAP_REFRESH;
                    6: code = omv_pkg::CAP_PRIVATE;
                    default: code = 8'($urandom);
                endcase
                if ($urandom_range(5) == 0)
                    repeat ($urandom_range(1, 3)) val.push_back(8'($urandom));
                if ($urandom_range(9) == 0)
                    while (val.size() > 0 && $urandom_range(1) == 1) void'(val.pop_back());
                par.push_back(code);
                par.push_back(8'(val.size()));
                foreach (val[i]) par.push_back(val[i]);
            end
            case ($urandom_range(19))
                0: opts.push_back(omv_pkg::OPT_AUTH);
                1: opts.push_back(8'($urandom));
                default: opts.push_back(omv_pkg::OPT_CAPS);
            endcase
            opts.push_back(8'(par.size()));
            foreach (par[i]) opts.push_back(par[i]);
        end
        m.push_back(8'(opts.size()));
        foreach (opts[i]) m.push_back(opts[i]);
        // broken messages: one byte hit, or cut short by the next start
        if ($urandom_range(99) < 12) begin
            idx = $urandom_range(0, m.size() - 1);
            m[idx] = 8'($urandom);
        end
        if ($urandom_range(99) < 6) begin
            idx = $urandom_range(1, m.size());
            while (m.size() > idx) void'(m.pop_back());
        end
        foreach (m[i]) begin
            x.b = m[i];
            x.sof = (i == 0);
            pending_words.push_back(x);
        end
        if ($urandom_range(99) < 5) loose(8'($urandom));
        nbytes = m.size();
    endtask

    initial begin : stimulus
        int          queued;
        int          n;
        logic [31:0] peer;
        logic        en;
        logic [7:0]  b;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, 16-bit peer as with 4-octet check on
        write_reg(omv_pkg::CFG_PEER_AS, 32'(PEER16));
        write_reg(omv_pkg::CFG_AS4_EN, 1'b1);
        loose(8'h00);
        loose(8'hFF);
        send(8'hFF, 1);
        send(8'h00, 1);
        send({omv_pkg::BGP_VERSION, 16'hFDE9}, 3);
        send({omv_pkg::BGP_VERSION, PEER16, 16'd1}, 5);
        send({omv_pkg::BGP_VERSION, PEER16}, 3);
        send(hdr(PEER16, 16'hFFFF, 8'd0), 10);
        send({hdr(PEER16, 16'd0, 8'd2), 16'h0100}, 12);
        send({hdr(PEER16, 16'd180, 8'd2), 16'h0300}, 12);
        send({hdr(PEER16, 16'd180, 8'd1), 8'h02}, 11);
        send({hdr(PEER16, 16'd180, 8'd3), 16'h0205}, 12);
        send({hdr(PEER16, 16'd180, 8'd8), 64'h0206_0104_0002_0003}, 18);
        send({hdr(PEER16, 16'd180, 8'd8), 48'h0206_0104_0003}, 16);
        send({hdr(PEER16, 16'd180, 8'd8), 64'h0206_0104_0001_0004}, 18);
        send({hdr(PEER16, 16'd180, 8'd8), 32'h0206_0102}, 14);
        send({hdr(PEER16, 16'd180, 8'd4), 24'h0202_07}, 13);
        send({hdr(PEER16, 16'd180, 8'd3), 24'h0201_02}, 13);
        send({hdr(PEER16, 16'd180, 8'd4), 32'h0202_0205}, 14);
        send({hdr(PEER16, 16'd180, 8'd13), 16'h020B, 16'h0200, 24'h8001AA,
              16'h4104, 32'h0000_FDE8}, 23);
        send({hdr(PEER16, 16'd180, 8'd8), 32'h0206_4104, 32'h0001_0000}, 18);
        send({hdr(PEER16, 16'd180, 8'd8), 32'h0206_4103}, 14);
        send({hdr(PEER16, 16'd180, 8'd16), 80'h0208_0106_0001_0001_FFFF,
              32'h0202_0200, 16'h0200}, 26);
        drain();

        // directed, peer as too wide for two octets
        write_reg(omv_pkg::CFG_PEER_AS, 32'hFFFF_FFFF);
        write_reg(omv_pkg::CFG_AS4_EN, 1'b0);
        send({omv_pkg::BGP_VERSION, 16'hFFFF}, 3);
        send({hdr(omv_pkg::AS_STANDIN, 16'd3, 8'd14), 16'h020C, 48'h4104_1122_3344,
              48'h4104_FFFF_FFFF}, 24);
        drain();
        write_reg(omv_pkg::CFG_AS4_EN, 1'b1);
        send({hdr(omv_pkg::AS_STANDIN, 16'd3, 8'd8), 32'h0206_4104, 32'hFFFF_FFFF}, 18);
        drain();

        // random messages under each pacing
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin peer = 32'd0;         en = 1'b1; tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin peer = 32'hFFFF_FFFF; en = 1'b1; tx_idle_pct = 57; rx_stall_pct = 0;  end
                2: begin peer = 32'd65535;     en = 1'b0; tx_idle_pct = 0;  rx_stall_pct = 57; end
                default: begin
                    peer = $urandom;
                    en = 1'($urandom);
                    tx_idle_pct = 11;
                    rx_stall_pct = 11;
                end
            endcase
            write_reg(omv_pkg::CFG_PEER_AS, peer);
            write_reg(omv_pkg::CFG_AS4_EN, en);
            queued = 0;
            while (queued < 70) begin
                add_random_msg(n);
                queued += n;
            end
            drain();
        end

        // receiver holds off while bad version words keep coming
        write_reg(omv_pkg::CFG_PEER_AS, 32'h0001_0000);
        write_reg(omv_pkg::CFG_AS4_EN, 1'b1);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_off_req++;
        repeat (40) begin
            b = 8'($urandom);
            if (b == omv_pkg::BGP_VERSION) b = 8'hFF;
            send(b, 1);
        end
        drain();
        tx_idle_pct = 11;
        rx_stall_pct = 11;
        queued = 0;
        while (queued < 40) begin
            add_random_msg(n);
            queued += n;
        end
        drain();
        repeat (10) @(posedge i_clk);

        $display("%0d message words in, %0d verdicts checked: directed cases, four pacing mixes",
                 words_sent, verdicts_seen);
        $display("and a long receiver hold-off; ok %0d version %0d as %0d hold %0d",
                 verdict_tally[omv_pkg::V_OK], verdict_tally[omv_pkg::V_VERSION],
                 verdict_tally[omv_pkg::V_BAD_AS], verdict_tally[omv_pkg::V_HOLD_TIME]);
        $display("auth %0d param %0d cap %0d",
                 verdict_tally[omv_pkg::V_AUTH], verdict_tally[omv_pkg::V_BAD_PARAM],
                 verdict_tally[omv_pkg::V_BAD_CAP]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
